FILE: rtl/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Types, constants and codes shared by the positional list engine modules.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;

    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_OVERWRITE = 2'd2,
        OP_SEARCH    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic        [POS_W-1:0]   found_position;
        logic        [POS_W-1:0]   list_length;
    } rsp_t;

    typedef struct packed {
        logic                      valid;
        rsp_t                      word;
    } res_t;

    typedef struct packed {
        logic                      we;
        logic        [ADDR_W-1:0]  waddr;
        logic        [DATA_W-1:0]  wdata;
        logic        [ADDR_W-1:0]  raddr;
    } mem_req_t;

endpackage

FILE: rtl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit entries with insert, delete, overwrite and
// search by value.
//
// Request channel req_valid / req_stall / req carries one request word; it is
// taken at a clock edge with req_valid high and req_stall low. The result
// channel rsp_valid / rsp_stall / rsp returns one result word per request.
// One request is worked at a time; req_stall is high from acceptance until
// its result has moved into the output register.
// A request rejected at decode, or a delete of the last entry, goes straight
// to its result; overwrite and append write one entry first. An insert or a
// delete first moves the later entries one place up or down, and a search
// compares entries from position 1 until it hits or reaches the list's end.
// The entry memory port moves or compares one entry per cycle.
// The output register lets the next request be accepted while a result waits
// under rsp_stall; a second result waits inside the sequencer and holds off
// further requests. Reset empties the list; memory contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  plist_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output plist_pkg::rsp_t   rsp
);

    plist_pkg::res_t                  res;
    plist_pkg::mem_req_t              mem;
    logic [plist_pkg::DATA_W-1:0]     rdata;
    logic                             res_take;
    logic                             rsp_valid_reg;
    plist_pkg::rsp_t                  rsp_reg;

    assign res_take = !rsp_valid_reg || !rsp_stall;

    plist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (req_stall),
        .res       (res),
        .res_take  (res_take),
        .mem       (mem),
        .rdata     (rdata)
    );

    plist_ram #(
        .WIDTH (plist_pkg::DATA_W),
        .DEPTH (plist_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res.valid)
        begin
            rsp_reg <= res.word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/plist_ram.sv
// ----------------------------------------------------------------------------
// plist_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/plist_ctrl.sv
// ----------------------------------------------------------------------------
// plist_ctrl
// Request sequencer: decodes a request, shifts or scans the entry memory one
// entry per cycle and builds the result word.
// ----------------------------------------------------------------------------
module plist_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    input  plist_pkg::req_t                       req,
    output logic                                  busy,
    output plist_pkg::res_t                       res,
    input  logic                                  res_take,
    output plist_pkg::mem_req_t                   mem,
    input  logic [plist_pkg::DATA_W-1:0]          rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_DRAIN,
        S_DN,
        S_DN_DRAIN,
        S_SCAN,
        S_WRITE,
        S_RESP
    } state_t;

    state_t                         state_reg, state_next;
    logic [plist_pkg::POS_W-1:0]    length_reg, length_next;
    logic [plist_pkg::ADDR_W-1:0]   cur_reg, cur_next;
    logic [plist_pkg::ADDR_W-1:0]   src_reg, src_next;
    logic [plist_pkg::ADDR_W-1:0]   bound_reg, bound_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic [plist_pkg::DATA_W-1:0]   val_reg, val_next;
    plist_pkg::status_t             status_reg, status_next;
    logic [plist_pkg::POS_W-1:0]    found_reg, found_next;

    logic                           accept;
    logic [plist_pkg::POS_W-1:0]    pos_m1;
    logic [plist_pkg::POS_W-1:0]    len_m1;
    logic [plist_pkg::POS_W:0]      len_p1;

    assign accept = req_valid && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign pos_m1 = req.position - plist_pkg::POS_W'(1);
    assign len_m1 = length_reg - plist_pkg::POS_W'(1);
    assign len_p1 = {1'b0, length_reg} + (plist_pkg::POS_W + 1)'(1);

    assign res.valid               = (state_reg == S_RESP);
    assign res.word.status         = status_reg;
    assign res.word.found_position = found_reg;
    assign res.word.list_length    = length_reg;

    always_comb
    begin
        state_next    = state_reg;
        length_next   = length_reg;
        cur_next      = cur_reg;
        src_next      = src_reg;
        bound_next    = bound_reg;
        rd_valid_next = rd_valid_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        mem.we        = 1'b0;
        mem.waddr     = bound_reg;
        mem.wdata     = val_reg;
        mem.raddr     = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    val_next      = req.value;
                    status_next   = plist_pkg::ST_OK;
                    found_next    = '0;
                    rd_valid_next = 1'b0;
                    state_next    = S_RESP;
                    if (req.op == plist_pkg::OP_SEARCH)
                    begin
                        if (length_reg == '0)
                        begin
                            status_next = plist_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cur_next   = '0;
                            bound_next = len_m1[plist_pkg::ADDR_W-1:0];
                            state_next = S_SCAN;
                        end
                    end
                    else if (req.position > plist_pkg::CAP_POS)
                    begin
                        status_next = plist_pkg::ST_OVERFLOW;
                    end
                    else if (req.op == plist_pkg::OP_INSERT)
                    begin
                        priority if (req.position == '0 || {1'b0, req.position} > len_p1)
                        begin
                            status_next = plist_pkg::ST_BADPOS;
                        end
                        else if (length_reg == plist_pkg::CAP_POS)
                        begin
                            status_next = plist_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            length_next = length_reg + plist_pkg::POS_W'(1);
                            bound_next  = pos_m1[plist_pkg::ADDR_W-1:0];
                            cur_next    = len_m1[plist_pkg::ADDR_W-1:0];
                            if ({1'b0, req.position} == len_p1)
                            begin
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                state_next = S_UP;
                            end
                        end
                    end
                    else if (req.position == '0 || req.position > length_reg)
                    begin
                        status_next = plist_pkg::ST_BADPOS;
                    end
                    else if (req.op == plist_pkg::OP_DELETE)
                    begin
                        length_next = len_m1;
                        if (req.position != length_reg)
                        begin
                            cur_next   = req.position[plist_pkg::ADDR_W-1:0];
                            bound_next = len_m1[plist_pkg::ADDR_W-1:0];
                            state_next = S_DN;
                        end
                    end
                    else
                    begin
                        bound_next = pos_m1[plist_pkg::ADDR_W-1:0];
                        state_next = S_WRITE;
                    end
                end
            end

            S_UP:
            begin
                mem.raddr     = cur_reg;
                mem.we        = rd_valid_reg;
                mem.waddr     = src_reg + plist_pkg::ADDR_W'(1);
                mem.wdata     = rdata;
                src_next      = cur_reg;
                rd_valid_next = 1'b1;
                if (cur_reg == bound_reg)
                begin
                    state_next = S_UP_DRAIN;
                end
                else
                begin
                    cur_next = cur_reg - plist_pkg::ADDR_W'(1);
                end
            end

            S_UP_DRAIN:
            begin
                mem.we     = 1'b1;
                mem.waddr  = src_reg + plist_pkg::ADDR_W'(1);
                mem.wdata  = rdata;
                state_next = S_WRITE;
            end

            S_DN:
            begin
                mem.raddr     = cur_reg;
                mem.we        = rd_valid_reg;
                mem.waddr     = src_reg - plist_pkg::ADDR_W'(1);
                mem.wdata     = rdata;
                src_next      = cur_reg;
                rd_valid_next = 1'b1;
                if (cur_reg == bound_reg)
                begin
                    state_next = S_DN_DRAIN;
                end
                else
                begin
                    cur_next = cur_reg + plist_pkg::ADDR_W'(1);
                end
            end

            S_DN_DRAIN:
            begin
                mem.we     = 1'b1;
                mem.waddr  = src_reg - plist_pkg::ADDR_W'(1);
                mem.wdata  = rdata;
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                mem.raddr     = cur_reg;
                cur_next      = cur_reg + plist_pkg::ADDR_W'(1);
                src_next      = cur_reg;
                rd_valid_next = 1'b1;
                if (rd_valid_reg && rdata == val_reg)
                begin
                    found_next  = plist_pkg::POS_W'(src_reg) + plist_pkg::POS_W'(1);
                    status_next = plist_pkg::ST_OK;
                    state_next  = S_RESP;
                end
                else if (rd_valid_reg && src_reg == bound_reg)
                begin
                    status_next = plist_pkg::ST_NOTFOUND;
                    state_next  = S_RESP;
                end
            end

            S_WRITE:
            begin
                mem.we     = 1'b1;
                mem.waddr  = bound_reg;
                mem.wdata  = val_reg;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            length_reg   <= '0;
            rd_valid_reg <= 1'b0;
            status_reg   <= plist_pkg::ST_OK;
            found_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            rd_valid_reg <= rd_valid_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        src_reg   <= src_next;
        bound_reg <= bound_next;
        val_reg   <= val_next;
    end

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= plist_pkg::CAP_POS)
        else $error("list length above capacity");

    a_shift_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP || state_reg == S_DN) && rd_valid_reg |-> mem.waddr != mem.raddr)
        else $error("shift writes the entry it reads");

    a_len_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> length_reg == $past(length_reg))
        else $error("length changed without a request");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.word.found_position != '0 |-> res.word.status == plist_pkg::ST_OK)
        else $error("found position with error status");

endmodule
